@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock while out of reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

@@ sv/hpfc_pkg.sv @@
package hpfc_pkg;

    localparam logic [1:0] FUNC_S2H  = 2'd0;
    localparam logic [1:0] FUNC_H2S  = 2'd1;
    localparam logic [1:0] FUNC_S2BF = 2'd2;
    localparam logic [1:0] FUNC_BF2S = 2'd3;

    localparam logic [31:0] SGL_INF      = 32'h7f80_0000;
    localparam logic [31:0] HALF_OVF_AT  = 32'h4780_0000;
    localparam logic [31:0] HALF_MIN_NRM = 32'h3880_0000;
    localparam logic [15:0] HALF_NAN     = 16'h7e00;
    localparam logic [15:0] HALF_INF     = 16'h7c00;
    localparam logic [15:0] BF_NAN       = 16'h7fc0;

    // stage 1 -> stage 2 classification
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] op;
        logic        sgn;
        logic        is_nan;
        logic        big;
        logic        tiny;
        logic [4:0]  sh;        // subnormal shift minus 14, 0..31
        logic        zero_out;  // shift of 26 or more
        logic [3:0]  lead;      // half subnormal leading one position
    } hpfc_cls_t;

endpackage

@@ sv/hpfc_stage.sv @@
// one pipeline stage with valid/ready and stall hold
module hpfc_stage #(
    parameter int Width = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [Width-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Width-1:0] out_data
);
    logic             valid_reg;
    logic [Width-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end
endmodule

@@ sv/half_precision_format_converter.sv @@
// Converts one value per request between single precision and half or bfloat16,
// selected by func (0 single->half, 1 half->single, 2 single->bfloat16,
// 3 bfloat16->single). Three register stages (classify, shift/round, pack)
// take one request per cycle while the output is not stalled; a request
// passes the classify, shift/round and pack registers in that order, and a
// stall holds every full stage without loss while empty stages still fill.
module half_precision_format_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_bits
);
    import hpfc_pkg::*;
    `include "assert_macros.svh"

    localparam int ClsW = $bits(hpfc_cls_t);

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] op;
        logic        sgn;
        logic        is_nan;
        logic        big;
        logic        tiny;
        logic        zero_out;
        logic [15:0] sub_q;   // rounded subnormal half
        logic [3:0]  lead;
    } s2_t;
    localparam int S2W = $bits(s2_t);

    // stage 1: classify
    hpfc_cls_t c1;
    logic [30:0] mag;
    logic [7:0]  e1;
    logic [7:0]  shf;
    always_comb
    begin
        mag = operand_bits[30:0];
        e1 = (operand_bits[30:23] == 8'd0) ? 8'd1 : operand_bits[30:23];
        shf = 8'd112 - e1;    // 126 - e - 14
        c1.func = func;
        c1.op = operand_bits;
        c1.sgn = operand_bits[31];
        c1.is_nan = {1'b0, mag} > SGL_INF;
        c1.big = {1'b0, mag} >= HALF_OVF_AT;
        c1.tiny = {1'b0, mag} < HALF_MIN_NRM;
        c1.zero_out = (shf >= 8'd12) || (operand_bits[30:23] < 8'd100);
        c1.sh = shf[4:0];
        c1.lead = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (operand_bits[i])
            begin
                c1.lead = 4'(i);
            end
        end
    end

    logic            v1, r1, v2, r2;
    logic [ClsW-1:0] d1;
    logic [S2W-1:0]  d2;
    hpfc_cls_t       c2;

    hpfc_stage #(.Width(ClsW)) u_s1 (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(c1), .out_valid(v1), .out_ready(r1), .out_data(d1));

    // stage 2: subnormal shift and round
    s2_t  n2;
    logic [23:0] m2;
    logic [4:0]  shr;
    logic [48:0] ext;
    logic [23:0] q;
    logic [24:0] rem;
    logic [24:0] hlf;
    always_comb
    begin
        c2 = hpfc_cls_t'(d1);
        m2 = {(c2.op[30:23] != 8'd0), c2.op[22:0]};
        shr = 5'd14 + c2.sh;
        // for shifts up to 25 every shifted-out bit lands in the remainder, half at its msb
        ext = {m2, 25'd0} >> shr;
        q = ext[48:25];
        rem = ext[24:0];
        hlf = 25'h100_0000;
        n2.func = c2.func;
        n2.op = c2.op;
        n2.sgn = c2.sgn;
        n2.is_nan = c2.is_nan;
        n2.big = c2.big;
        n2.tiny = c2.tiny;
        n2.zero_out = c2.zero_out;
        n2.lead = c2.lead;
        n2.sub_q = q[15:0];
        if ((rem > hlf) || ((rem == hlf) && q[0]))
        begin
            n2.sub_q = q[15:0] + 16'd1;
        end
    end

    hpfc_stage #(.Width(S2W)) u_s2 (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .in_ready(r1),
        .in_data(n2), .out_valid(v2), .out_ready(r2), .out_data(d2));

    // stage 3: pack result
    s2_t         s3;
    logic [31:0] res;
    logic [31:0] a3;
    logic [31:0] t3;
    logic [31:0] u3;
    logic [15:0] h;
    always_comb
    begin
        s3 = s2_t'(d2);
        a3 = {1'b0, s3.op[30:0]};
        t3 = a3 - 32'h3800_0000 + 32'h0000_0fff + {31'd0, a3[13]};
        u3 = s3.op + {31'd0, s3.op[16]} + 32'h0000_7fff;
        h = s3.op[15:0];
        res = 32'd0;
        unique case (s3.func)
            FUNC_S2H:
            begin
                if (s3.big)
                    res[15:0] = s3.is_nan ? HALF_NAN : HALF_INF;
                else if (s3.tiny)
                    res[15:0] = s3.zero_out ? 16'd0 : s3.sub_q;
                else
                    res[15:0] = t3[28:13];
                res[15] = res[15] | s3.sgn;
            end
            FUNC_H2S:
            begin
                if (h[14:10] == 5'h1f)
                    res = SGL_INF | {9'd0, h[9:0], 13'd0};
                else if (h[14:10] != 5'd0)
                    res = {1'b0, 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
                else if (h[9:0] != 10'd0)
                    res = {1'b0, 8'(s3.lead) + 8'd103,
                           23'({h[9:0], 13'd0} << (5'd10 - 5'(s3.lead)))};
                res[31] = h[15];
            end
            FUNC_S2BF:
            begin
                res[15:0] = s3.is_nan ? BF_NAN : u3[31:16];
            end
            FUNC_BF2S:
            begin
                res = {h, 16'd0};
            end
            default:
            begin
                res = 32'd0;
            end
        endcase
    end

    logic [31:0] out_reg;
    logic        ov_reg;
    assign r2 = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign result_bits = out_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (r2)
            ov_reg <= v2;
    end
    always_ff @(posedge clk)
    begin
        if (r2 && v2)
            out_reg <= res;
    end

    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_bits))
    `ASSERT_IMPLY(a_half_up, clk, rst_n, out_valid && !in_ready, !out_ready)
    `ASSERT_IMPLY(a_s1_fwd, clk, rst_n, v1 && !r1, v2 && !r2)
endmodule
